// File: rtl/core/rvx_pkg.sv
// Shared types and constants for the RV64I integer execute block.
// Used by rvx_exec and rv64i_integer_execute; no dependencies.
package rvx_pkg;

	localparam int XLEN          = 64;
	localparam int REG_FIELD_W   = 5;
	localparam int REG_COUNT_DEF = 32;
	// one more bit than a register field, so a count of 32 compares cleanly
	localparam int REG_CMP_W     = REG_FIELD_W + 1;

	localparam logic [XLEN-1:0] INSN_BYTES = 64'd4;

	// major opcodes
	localparam logic [6:0] OP_LUI    = 7'h37;
	localparam logic [6:0] OP_AUIPC  = 7'h17;
	localparam logic [6:0] OP_JAL    = 7'h6f;
	localparam logic [6:0] OP_JALR   = 7'h67;
	localparam logic [6:0] OP_BRANCH = 7'h63;
	localparam logic [6:0] OP_LOAD   = 7'h03;
	localparam logic [6:0] OP_STORE  = 7'h23;
	localparam logic [6:0] OP_IMM    = 7'h13;
	localparam logic [6:0] OP_REG    = 7'h33;
	localparam logic [6:0] OP_IMM32  = 7'h1b;
	localparam logic [6:0] OP_REG32  = 7'h3b;

	// funct3 codes
	localparam logic [2:0] F3_ADD  = 3'd0;
	localparam logic [2:0] F3_SLL  = 3'd1;
	localparam logic [2:0] F3_SLT  = 3'd2;
	localparam logic [2:0] F3_SLTU = 3'd3;
	localparam logic [2:0] F3_XOR  = 3'd4;
	localparam logic [2:0] F3_SR   = 3'd5;
	localparam logic [2:0] F3_OR   = 3'd6;
	localparam logic [2:0] F3_AND  = 3'd7;

	localparam logic [2:0] F3_BEQ  = 3'd0;
	localparam logic [2:0] F3_BNE  = 3'd1;
	localparam logic [2:0] F3_BLT  = 3'd4;
	localparam logic [2:0] F3_BGE  = 3'd5;
	localparam logic [2:0] F3_BLTU = 3'd6;
	localparam logic [2:0] F3_BGEU = 3'd7;

	localparam logic [2:0] F3_LOAD_BAD = 3'd7;
	localparam logic [2:0] F3_STORE_MAX = 3'd3;

	localparam logic [6:0] F7_BASE = 7'h00;
	localparam logic [6:0] F7_ALT  = 7'h20;
	localparam logic [5:0] TOP6_LOGIC = 6'h00;
	localparam logic [5:0] TOP6_ARITH = 6'h10;

	// access sizes
	localparam logic [1:0] SIZE_B = 2'd0;
	localparam logic [1:0] SIZE_H = 2'd1;
	localparam logic [1:0] SIZE_W = 2'd2;
	localparam logic [1:0] SIZE_D = 2'd3;

	localparam logic KIND_EXEC = 1'b0;
	localparam logic KIND_LOAD_RET = 1'b1;

	typedef struct packed {
		logic            kind;
		logic [31:0]     instruction;
		logic [XLEN-1:0] pc;
		logic [XLEN-1:0] load_data;
	} item_t;

	typedef struct packed {
		logic                   redirect;
		logic [XLEN-1:0]        next_pc;
		logic                   mem_read;
		logic                   mem_write;
		logic [XLEN-1:0]        mem_addr;
		logic [XLEN-1:0]        mem_wdata;
		logic [1:0]             mem_size;
		logic                   wb_valid;
		logic [REG_FIELD_W-1:0] wb_index;
		logic [XLEN-1:0]        wb_value;
		logic                   unsupported;
	} result_t;

	// register file write request
	typedef struct packed {
		logic                   en;
		logic [REG_FIELD_W-1:0] idx;
		logic [XLEN-1:0]        value;
	} wb_t;

	// outstanding load
	typedef struct packed {
		logic [REG_FIELD_W-1:0] dest;
		logic [1:0]             size;
		logic                   uns;
	} pend_t;

endpackage

// File: rtl/core/rv64i_integer_execute.sv
// RV64I execute block: register file memory, operand forwarding, output register.
// Depends on rvx_pkg and rvx_exec.
// An accepted item beat passes stage 1, then the output register; one beat per cycle
// unless the result stalls. A stalled result holds the stage and stalls the item side in
// the same cycle. Operands are read from the two-read-port register memory at accept; the
// stage-1 write back is forwarded from a last-write register. Reset clears per-register
// valid bits (register file reads as zero), the pending load, and both valid flags.
module rv64i_integer_execute #(
	parameter int REG_COUNT = rvx_pkg::REG_COUNT_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_stall,
	input  rvx_pkg::item_t   item,
	output logic             result_valid,
	input  logic             result_stall,
	output rvx_pkg::result_t result
);

	localparam int IDX_W = $clog2(REG_COUNT);

	logic [rvx_pkg::XLEN-1:0] rf_mem [REG_COUNT];
	logic [REG_COUNT-1:0]     rf_vld_q;

	logic                     valid_s1;
	rvx_pkg::item_t           item_s1;
	logic [rvx_pkg::XLEN-1:0] rd1_s1, rd2_s1;
	logic                     ok1_s1, ok2_s1;

	logic                     byp_en_q;
	logic [rvx_pkg::REG_FIELD_W-1:0] byp_idx_q;
	logic [rvx_pkg::XLEN-1:0] byp_val_q;

	rvx_pkg::pend_t           pend_q, pend_next;
	rvx_pkg::result_t         res;
	rvx_pkg::wb_t             wb;

	logic                     accept, adv, wr_en;
	logic [rvx_pkg::REG_FIELD_W-1:0] rs1_in, rs2_in, rs1_s1, rs2_s1;
	logic                     rs1_in_rng, rs2_in_rng;
	logic [rvx_pkg::XLEN-1:0] op_a, op_b;

	assign adv        = valid_s1 && (!result_valid || !result_stall);
	assign item_stall = valid_s1 && !adv;
	assign accept     = item_valid && !item_stall;
	assign wr_en      = adv && wb.en;

	assign rs1_in = item.instruction[19:15];
	assign rs2_in = item.instruction[24:20];
	assign rs1_s1 = item_s1.instruction[19:15];
	assign rs2_s1 = item_s1.instruction[24:20];
	assign rs1_in_rng = {1'b0, rs1_in} < rvx_pkg::REG_CMP_W'(REG_COUNT);
	assign rs2_in_rng = {1'b0, rs2_in} < rvx_pkg::REG_CMP_W'(REG_COUNT);

	// register memory: one write, two registered reads
	always_ff @(posedge clk) begin
		if (wr_en)
			rf_mem[wb.idx[IDX_W-1:0]] <= wb.value;
		if (accept) begin
			rd1_s1  <= rf_mem[rs1_in[IDX_W-1:0]];
			rd2_s1  <= rf_mem[rs2_in[IDX_W-1:0]];
			item_s1 <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rf_vld_q <= '0;
			valid_s1 <= 1'b0;
			ok1_s1   <= 1'b0;
			ok2_s1   <= 1'b0;
			byp_en_q <= 1'b0;
			byp_idx_q <= '0;
			pend_q   <= '0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
				ok1_s1 <= rs1_in_rng && rf_vld_q[rs1_in[IDX_W-1:0]];
				ok2_s1 <= rs2_in_rng && rf_vld_q[rs2_in[IDX_W-1:0]];
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			if (adv)
				pend_q <= pend_next;
			if (wr_en) begin
				rf_vld_q[wb.idx[IDX_W-1:0]] <= 1'b1;
				byp_en_q  <= 1'b1;
				byp_idx_q <= wb.idx;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en)
			byp_val_q <= wb.value;
	end

	// forward the write that landed on the same edge as the operand read
	always_comb begin
		if (byp_en_q && byp_idx_q == rs1_s1)
			op_a = byp_val_q;
		else
			op_a = ok1_s1 ? rd1_s1 : '0;
		if (byp_en_q && byp_idx_q == rs2_s1)
			op_b = byp_val_q;
		else
			op_b = ok2_s1 ? rd2_s1 : '0;
	end

	rvx_exec #(
		.REG_COUNT (REG_COUNT)
	) u_exec (
		.item      (item_s1),
		.a         (op_a),
		.b         (op_b),
		.pend      (pend_q),
		.res       (res),
		.wb        (wb),
		.pend_next (pend_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (adv) begin
			result_valid <= 1'b1;
		end else if (!result_stall) begin
			result_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv)
			result <= res;
	end

endmodule

// File: rtl/core/rvx_exec.sv
// Decode and execute datapath for one RV64I item, given forwarded operands.
// Depends on rvx_pkg for item, result, write and pending-load types.
module rvx_exec #(
	parameter int REG_COUNT = rvx_pkg::REG_COUNT_DEF
) (
	input  rvx_pkg::item_t               item,
	input  logic [rvx_pkg::XLEN-1:0]     a,
	input  logic [rvx_pkg::XLEN-1:0]     b,
	input  rvx_pkg::pend_t               pend,
	output rvx_pkg::result_t             res,
	output rvx_pkg::wb_t                 wb,
	output rvx_pkg::pend_t               pend_next
);

	logic [31:0]                  ins;
	logic [6:0]                   op;
	logic [rvx_pkg::REG_FIELD_W-1:0] rd;
	logic [2:0]                   f3;
	logic [6:0]                   f7;
	logic [5:0]                   top6;
	logic [5:0]                   shi;
	logic [5:0]                   shr;
	logic [rvx_pkg::XLEN-1:0]     immi, imms, immb, immu, immj;
	logic [rvx_pkg::XLEN-1:0]     sum_ai, sum_ab, diff_ab, val, ld;
	logic [31:0]                  w_val;
	logic                         has_wb, bad, taken;
	logic                         rd_ok, pd_ok;

	assign ins  = item.instruction;
	assign op   = ins[6:0];
	assign rd   = ins[11:7];
	assign f3   = ins[14:12];
	assign f7   = ins[31:25];
	assign top6 = ins[31:26];
	assign shi  = ins[25:20];
	assign shr  = b[5:0];

	assign immi = {{52{ins[31]}}, ins[31:20]};
	assign imms = {{52{ins[31]}}, ins[31:25], ins[11:7]};
	assign immb = {{51{ins[31]}}, ins[31], ins[7], ins[30:25], ins[11:8], 1'b0};
	assign immu = {{32{ins[31]}}, ins[31:12], 12'b0};
	assign immj = {{43{ins[31]}}, ins[31], ins[19:12], ins[20], ins[30:21], 1'b0};

	assign sum_ai  = a + immi;
	assign sum_ab  = a + b;
	assign diff_ab = a - b;

	assign rd_ok = (rd != '0) &&
		({1'b0, rd} < rvx_pkg::REG_CMP_W'(REG_COUNT));
	assign pd_ok = (pend.dest != '0) &&
		({1'b0, pend.dest} < rvx_pkg::REG_CMP_W'(REG_COUNT));

	// extend returned load data by the pending size
	always_comb begin
		unique case (pend.size)
			rvx_pkg::SIZE_B: ld = pend.uns ? {56'b0, item.load_data[7:0]}
				: {{56{item.load_data[7]}}, item.load_data[7:0]};
			rvx_pkg::SIZE_H: ld = pend.uns ? {48'b0, item.load_data[15:0]}
				: {{48{item.load_data[15]}}, item.load_data[15:0]};
			rvx_pkg::SIZE_W: ld = pend.uns ? {32'b0, item.load_data[31:0]}
				: {{32{item.load_data[31]}}, item.load_data[31:0]};
			default:         ld = item.load_data;
		endcase
	end

	always_comb begin
		res       = '0;
		wb        = '0;
		pend_next = pend;
		val       = '0;
		w_val     = '0;
		has_wb    = 1'b0;
		bad       = 1'b0;
		taken     = 1'b0;

		if (item.kind == rvx_pkg::KIND_LOAD_RET) begin
			if (pd_ok) begin
				wb.en         = 1'b1;
				wb.idx        = pend.dest;
				wb.value      = ld;
				res.wb_valid  = 1'b1;
				res.wb_index  = pend.dest;
				res.wb_value  = ld;
			end
			pend_next.dest = '0;
		end else begin
			unique case (op)
				rvx_pkg::OP_LUI: begin
					val = immu;
					has_wb = 1'b1;
				end
				rvx_pkg::OP_AUIPC: begin
					val = item.pc + immu;
					has_wb = 1'b1;
				end
				rvx_pkg::OP_JAL: begin
					val = item.pc + rvx_pkg::INSN_BYTES;
					has_wb = 1'b1;
					res.redirect = 1'b1;
					res.next_pc = item.pc + immj;
				end
				rvx_pkg::OP_JALR: begin
					if (f3 != rvx_pkg::F3_ADD) begin
						bad = 1'b1;
					end else begin
						val = item.pc + rvx_pkg::INSN_BYTES;
						has_wb = 1'b1;
						res.redirect = 1'b1;
						res.next_pc = {sum_ai[63:1], 1'b0};
					end
				end
				rvx_pkg::OP_BRANCH: begin
					unique case (f3)
						rvx_pkg::F3_BEQ:  taken = a == b;
						rvx_pkg::F3_BNE:  taken = a != b;
						rvx_pkg::F3_BLT:  taken = $signed(a) < $signed(b);
						rvx_pkg::F3_BGE:  taken = $signed(a) >= $signed(b);
						rvx_pkg::F3_BLTU: taken = a < b;
						rvx_pkg::F3_BGEU: taken = a >= b;
						default:          bad = 1'b1;
					endcase
					if (taken) begin
						res.redirect = 1'b1;
						res.next_pc = item.pc + immb;
					end
				end
				rvx_pkg::OP_LOAD: begin
					if (f3 == rvx_pkg::F3_LOAD_BAD) begin
						bad = 1'b1;
					end else begin
						res.mem_read = 1'b1;
						res.mem_addr = sum_ai;
						res.mem_size = f3[1:0];
						pend_next.dest = rd;
						pend_next.size = f3[1:0];
						pend_next.uns  = f3[2];
					end
				end
				rvx_pkg::OP_STORE: begin
					if (f3 > rvx_pkg::F3_STORE_MAX) begin
						bad = 1'b1;
					end else begin
						res.mem_write = 1'b1;
						res.mem_addr  = a + imms;
						res.mem_wdata = b;
						res.mem_size  = f3[1:0];
					end
				end
				rvx_pkg::OP_IMM: begin
					has_wb = 1'b1;
					unique case (f3)
						rvx_pkg::F3_ADD:  val = sum_ai;
						rvx_pkg::F3_SLT:  val = {63'b0, $signed(a) < $signed(immi)};
						rvx_pkg::F3_SLTU: val = {63'b0, a < immi};
						rvx_pkg::F3_XOR:  val = a ^ immi;
						rvx_pkg::F3_OR:   val = a | immi;
						rvx_pkg::F3_AND:  val = a & immi;
						rvx_pkg::F3_SLL: begin
							bad = top6 != rvx_pkg::TOP6_LOGIC;
							val = a << shi;
						end
						default: begin
							if (top6 == rvx_pkg::TOP6_LOGIC)
								val = a >> shi;
							else if (top6 == rvx_pkg::TOP6_ARITH)
								val = $unsigned($signed(a) >>> shi);
							else
								bad = 1'b1;
						end
					endcase
				end
				rvx_pkg::OP_REG: begin
					has_wb = 1'b1;
					if (f7 == rvx_pkg::F7_BASE) begin
						unique case (f3)
							rvx_pkg::F3_ADD:  val = sum_ab;
							rvx_pkg::F3_SLL:  val = a << shr;
							rvx_pkg::F3_SLT:  val = {63'b0, $signed(a) < $signed(b)};
							rvx_pkg::F3_SLTU: val = {63'b0, a < b};
							rvx_pkg::F3_XOR:  val = a ^ b;
							rvx_pkg::F3_SR:   val = a >> shr;
							rvx_pkg::F3_OR:   val = a | b;
							default:          val = a & b;
						endcase
					end else if (f7 == rvx_pkg::F7_ALT && f3 == rvx_pkg::F3_ADD) begin
						val = diff_ab;
					end else if (f7 == rvx_pkg::F7_ALT && f3 == rvx_pkg::F3_SR) begin
						val = $unsigned($signed(a) >>> shr);
					end else begin
						bad = 1'b1;
					end
				end
				rvx_pkg::OP_IMM32: begin
					if (f3 != rvx_pkg::F3_ADD) begin
						bad = 1'b1;
					end else begin
						w_val  = sum_ai[31:0];
						val    = {{32{w_val[31]}}, w_val};
						has_wb = 1'b1;
					end
				end
				rvx_pkg::OP_REG32: begin
					has_wb = 1'b1;
					if (f3 == rvx_pkg::F3_ADD && f7 == rvx_pkg::F7_BASE)
						w_val = sum_ab[31:0];
					else if (f3 == rvx_pkg::F3_ADD && f7 == rvx_pkg::F7_ALT)
						w_val = diff_ab[31:0];
					else
						bad = 1'b1;
					val = {{32{w_val[31]}}, w_val};
				end
				default: bad = 1'b1;
			endcase

			if (bad) begin
				res = '0;
				res.unsupported = 1'b1;
				pend_next = pend;
			end else if (has_wb && rd_ok) begin
				wb.en        = 1'b1;
				wb.idx       = rd;
				wb.value     = val;
				res.wb_valid = 1'b1;
				res.wb_index = rd;
				res.wb_value = val;
			end
		end
	end

endmodule

// File: dv/tb_rv64i_integer_execute.sv
// Self-checking testbench for rv64i_integer_execute: directed and random RV64I beats
// checked against an in-bench execute predictor with its own register file.
// Depends on rvx_pkg and the rv64i_integer_execute RTL.
module tb_rv64i_integer_execute;
	import rvx_pkg::*;

	localparam int NREGS          = REG_COUNT_DEF;
	localparam int RANDOM_ITEMS   = 1400;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int REPORT_MAX     = 10;
	localparam int TAIL_CYCLES    = 8;

	localparam logic [6:0] OP_SYSTEM   = 7'h73;
	localparam logic [6:0] OP_MISC_MEM = 7'h0f;
	localparam logic [6:0] F7_MULDIV   = 7'h01;

	typedef struct packed {
		item_t beat;
		logic  drain;
	} stim_t;

	logic    clk          = 1'b0;
	logic    arst_n       = 1'b0;
	logic    item_valid   = 1'b0;
	logic    item_stall;
	item_t   item         = '0;
	logic    result_valid;
	logic    result_stall = 1'b0;
	result_t result;

	stim_t   stim_q[$];
	result_t outcome_q[$];
	logic    drain_next = 1'b0;
	logic    item_taken = 1'b0;
	int      send_gap   = 0;
	int      stall_left = 0;
	int      idle_cycles = 0;
	int      wrong_count = 0;
	logic [31:0] cycle_count = '0;

	// predictor state
	logic [63:0] xreg [NREGS];
	logic [4:0]  ld_dest;
	logic [1:0]  ld_size;
	logic        ld_uns;

	rv64i_integer_execute i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic logic [63:0] read_reg(logic [4:0] idx);
		if (idx == 5'd0 || idx >= NREGS) return 64'd0;
		return xreg[idx];
	endfunction

	function automatic logic reg_writable(logic [4:0] idx);
		return idx != 5'd0 && idx < NREGS;
	endfunction

	function automatic result_t execute_item(item_t it);
		result_t r;
		logic [31:0] w;
		logic [6:0]  op;
		logic [6:0]  f7;
		logic [2:0]  f3;
		logic [4:0]  rd;
		logic [63:0] a, b, immi, imms, immb, immu, immj, val, d;
		logic [5:0]  sh;
		logic        wb, bad, taken;
		r = '0;
		w = it.instruction;
		op = w[6:0];
		f3 = w[14:12];
		f7 = w[31:25];
		rd = w[11:7];
		a = read_reg(w[19:15]);
		b = read_reg(w[24:20]);
		immi = {{52{w[31]}}, w[31:20]};
		imms = {{52{w[31]}}, w[31:25], w[11:7]};
		immb = {{51{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
		immu = {{32{w[31]}}, w[31:12], 12'd0};
		immj = {{43{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
		sh = w[25:20];
		wb = 1'b0;
		bad = 1'b0;
		taken = 1'b0;
		val = '0;

		if (it.kind == KIND_LOAD_RET) begin
			d = it.load_data;
			case (ld_size)
				SIZE_B: d = ld_uns ? {56'd0, d[7:0]} : {{56{d[7]}}, d[7:0]};
				SIZE_H: d = ld_uns ? {48'd0, d[15:0]} : {{48{d[15]}}, d[15:0]};
				SIZE_W: d = ld_uns ? {32'd0, d[31:0]} : {{32{d[31]}}, d[31:0]};
				default: ;
			endcase
			if (reg_writable(ld_dest)) begin
				xreg[ld_dest] = d;
				r.wb_valid = 1'b1;
				r.wb_index = ld_dest;
				r.wb_value = d;
			end
			ld_dest = '0;
			return r;
		end

		case (op)
			OP_LUI: begin
				val = immu;
				wb = 1'b1;
			end
			OP_AUIPC: begin
				val = it.pc + immu;
				wb = 1'b1;
			end
			OP_JAL: begin
				val = it.pc + INSN_BYTES;
				wb = 1'b1;
				r.redirect = 1'b1;
				r.next_pc = it.pc + immj;
			end
			OP_JALR: begin
				if (f3 != F3_ADD) begin
					bad = 1'b1;
				end else begin
					val = it.pc + INSN_BYTES;
					wb = 1'b1;
					r.redirect = 1'b1;
					r.next_pc = (a + immi) & ~64'd1;
				end
			end
			OP_BRANCH: begin
				case (f3)
					F3_BEQ:  taken = a == b;
					F3_BNE:  taken = a != b;
					F3_BLT:  taken = $signed(a) < $signed(b);
					F3_BGE:  taken = !($signed(a) < $signed(b));
					F3_BLTU: taken = a < b;
					F3_BGEU: taken = a >= b;
					default: bad = 1'b1;
				endcase
			end
			OP_LOAD: begin
				if (f3 == F3_LOAD_BAD) begin
					bad = 1'b1;
				end else begin
					r.mem_read = 1'b1;
					r.mem_addr = a + immi;
					r.mem_size = f3[1:0];
					ld_dest = rd;
					ld_size = f3[1:0];
					ld_uns = f3[2];
				end
			end
			OP_STORE: begin
				if (f3 > F3_STORE_MAX) begin
					bad = 1'b1;
				end else begin
					r.mem_write = 1'b1;
					r.mem_addr = a + imms;
					r.mem_wdata = b;
					r.mem_size = f3[1:0];
				end
			end
			OP_IMM: begin
				wb = 1'b1;
				case (f3)
					F3_ADD:  val = a + immi;
					F3_SLT:  val = {63'd0, $signed(a) < $signed(immi)};
					F3_SLTU: val = {63'd0, a < immi};
					F3_XOR:  val = a ^ immi;
					F3_OR:   val = a | immi;
					F3_AND:  val = a & immi;
					F3_SLL: begin
						if (w[31:26] != TOP6_LOGIC) bad = 1'b1;
						val = a << sh;
					end
					default: begin
						if (w[31:26] == TOP6_LOGIC) val = a >> sh;
						else if (w[31:26] == TOP6_ARITH) val = $signed(a) >>> sh;
						else bad = 1'b1;
					end
				endcase
			end
			OP_REG: begin
				wb = 1'b1;
				if (f7 == F7_BASE) begin
					case (f3)
						F3_ADD:  val = a + b;
						F3_SLL:  val = a << b[5:0];
						F3_SLT:  val = {63'd0, $signed(a) < $signed(b)};
						F3_SLTU: val = {63'd0, a < b};
						F3_XOR:  val = a ^ b;
						F3_SR:   val = a >> b[5:0];
						F3_OR:   val = a | b;
						default: val = a & b;
					endcase
				end else if (f7 == F7_ALT && f3 == F3_ADD) begin
					val = a - b;
				end else if (f7 == F7_ALT && f3 == F3_SR) begin
					val = $signed(a) >>> b[5:0];
				end else begin
					bad = 1'b1;
				end
			end
			OP_IMM32: begin
				if (f3 != F3_ADD) begin
					bad = 1'b1;
				end else begin
					val = a + immi;
					val = {{32{val[31]}}, val[31:0]};
					wb = 1'b1;
				end
			end
			OP_REG32: begin
				wb = 1'b1;
				if (f3 == F3_ADD && f7 == F7_BASE) val = a + b;
				else if (f3 == F3_ADD && f7 == F7_ALT) val = a - b;
				else bad = 1'b1;
				val = {{32{val[31]}}, val[31:0]};
			end
			default: bad = 1'b1;
		endcase

		if (bad) begin
			r = '0;
			r.unsupported = 1'b1;
			return r;
		end
		if (taken) begin
			r.redirect = 1'b1;
			r.next_pc = it.pc + immb;
		end
		if (wb && reg_writable(rd)) begin
			xreg[rd] = val;
			r.wb_valid = 1'b1;
			r.wb_index = rd;
			r.wb_value = val;
		end
		return r;
	endfunction

	function automatic string field_diff(string name, logic [63:0] want, logic [63:0] got);
		if (want === got) return "";
		return $sformatf(" %s exp %0h got %0h", name, want, got);
	endfunction

	task automatic check_outcome(result_t got);
		result_t want;
		string   diffs;
		if (outcome_q.size() == 0) begin
			wrong_count++;
			if (wrong_count <= REPORT_MAX) $display("result beat with nothing pending: %h", got);
			return;
		end
		want = outcome_q.pop_front();
		diffs = {field_diff("redirect", 64'(want.redirect), 64'(got.redirect)),
			field_diff("next_pc", want.next_pc, got.next_pc),
			field_diff("mem_read", 64'(want.mem_read), 64'(got.mem_read)),
			field_diff("mem_write", 64'(want.mem_write), 64'(got.mem_write)),
			field_diff("mem_addr", want.mem_addr, got.mem_addr),
			field_diff("mem_wdata", want.mem_wdata, got.mem_wdata),
			field_diff("mem_size", 64'(want.mem_size), 64'(got.mem_size)),
			field_diff("wb_valid", 64'(want.wb_valid), 64'(got.wb_valid)),
			field_diff("wb_index", 64'(want.wb_index), 64'(got.wb_index)),
			field_diff("wb_value", want.wb_value, got.wb_value),
			field_diff("unsupported", 64'(want.unsupported), 64'(got.unsupported))};
		if (diffs != "") begin
			wrong_count++;
			if (wrong_count <= REPORT_MAX) $display("result mismatch:%s", diffs);
		end
	endtask

	// mostly short gaps, now and then a long one
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [63:0] rand64();
		logic [63:0] v;
		v = {$urandom(), $urandom()};
		case ($urandom_range(0, 9))
			0: v = 64'hffff_ffff_ffff_ffff - 64'($urandom_range(0, 15));
			1: v = 64'($urandom_range(0, 15));
			2: v = 64'h8000_0000_0000_0000 ^ 64'($urandom_range(0, 15));
			3: v = {32'd0, $urandom()};
			default: ;
		endcase
		return v;
	endfunction

	// favor low registers so back-to-back beats depend on each other
	function automatic logic [4:0] pick_reg();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0) return 5'd0;
		if (r < 5) return 5'($urandom_range(1, 7));
		return 5'($urandom_range(1, 31));
	endfunction

	function automatic logic [31:0] enc_i(logic [11:0] imm, logic [4:0] rs1, logic [2:0] f3,
		logic [4:0] rd, logic [6:0] op);
		return {imm, rs1, f3, rd, op};
	endfunction

	function automatic logic [31:0] enc_r(logic [6:0] f7, logic [4:0] rs2, logic [4:0] rs1,
		logic [2:0] f3, logic [4:0] rd, logic [6:0] op);
		return {f7, rs2, rs1, f3, rd, op};
	endfunction

	function automatic logic [31:0] enc_b(logic [12:0] imm, logic [4:0] rs2, logic [4:0] rs1,
		logic [2:0] f3);
		return {imm[12], imm[10:5], rs2, rs1, f3, imm[4:1], imm[11], OP_BRANCH};
	endfunction

	function automatic logic [31:0] random_insn();
		logic [31:0] w;
		logic [2:0]  f3;
		int          pick;
		int          r;
		w = $urandom();
		w[11:7] = pick_reg();
		w[19:15] = pick_reg();
		w[24:20] = pick_reg();
		f3 = w[14:12];
		pick = $urandom_range(0, 99);
		if (pick < 6) begin
			w[6:0] = OP_LUI;
		end else if (pick < 10) begin
			w[6:0] = OP_AUIPC;
		end else if (pick < 14) begin
			w[6:0] = OP_JAL;
		end else if (pick < 18) begin
			w[6:0] = OP_JALR;
			if ($urandom_range(0, 5) != 0) w[14:12] = F3_ADD;
		end else if (pick < 32) begin
			w[6:0] = OP_BRANCH;
			if ((f3 == 3'd2 || f3 == 3'd3) && $urandom_range(0, 3) != 0) w[14] = 1'b1;
			if ($urandom_range(0, 3) == 0) w[24:20] = w[19:15];
		end else if (pick < 38) begin
			w[6:0] = OP_LOAD;
		end else if (pick < 46) begin
			w[6:0] = OP_STORE;
			if ($urandom_range(0, 4) != 0) w[14] = 1'b0;
		end else if (pick < 66) begin
			w[6:0] = OP_IMM;
			if (f3 == F3_SLL && $urandom_range(0, 5) != 0) w[31:26] = TOP6_LOGIC;
			if (f3 == F3_SR) begin
				r = $urandom_range(0, 4);
				if (r == 1 || r == 2) w[31:26] = TOP6_LOGIC;
				else if (r > 2) w[31:26] = TOP6_ARITH;
			end
		end else if (pick < 84) begin
			w[6:0] = OP_REG;
			r = $urandom_range(0, 9);
			if (r < 6) begin
				w[31:25] = F7_BASE;
			end else if (r < 9) begin
				w[31:25] = F7_ALT;
				w[14:12] = $urandom_range(0, 1) ? F3_SR : F3_ADD;
			end
		end else if (pick < 89) begin
			w[6:0] = OP_IMM32;
			if ($urandom_range(0, 4) != 0) w[14:12] = F3_ADD;
		end else if (pick < 95) begin
			w[6:0] = OP_REG32;
			if ($urandom_range(0, 4) != 0) begin
				w[14:12] = F3_ADD;
				w[31:25] = $urandom_range(0, 1) ? F7_ALT : F7_BASE;
			end
		end else if (pick < 97) begin
			w[6:0] = $urandom_range(0, 1) ? OP_SYSTEM : OP_MISC_MEM;
		end else begin
			w = $urandom();
		end
		return w;
	endfunction

	task automatic queue_beat(logic kind, logic [31:0] w, logic [63:0] pc, logic [63:0] data);
		stim_t s;
		s.beat.kind = kind;
		s.beat.instruction = w;
		s.beat.pc = pc;
		s.beat.load_data = data;
		s.drain = drain_next;
		drain_next = 1'b0;
		stim_q.push_back(s);
	endtask

	task automatic queue_exec(logic [31:0] w);
		queue_beat(KIND_EXEC, w, rand64(), rand64());
	endtask

	task automatic queue_return(logic [63:0] data);
		queue_beat(KIND_LOAD_RET, $urandom(), rand64(), data);
	endtask

	// sample at the rising edge: results first, then the accepted item beat
	always @(posedge clk) begin
		cycle_count <= cycle_count + 32'd1;
		if (arst_n) begin
			if (result_valid && !result_stall) check_outcome(result);
			if (item_valid && !item_stall) outcome_q.push_back(execute_item(item));
			item_taken <= item_valid && !item_stall;
			if ((item_valid && !item_stall) || (result_valid && !result_stall))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
		end
	end

	// item driver: hold a stalled beat, otherwise advance after the gap
	always @(negedge clk) begin
		if (arst_n && (!item_valid || item_taken)) begin
			if (send_gap != 0) begin
				item_valid <= 1'b0;
				send_gap <= send_gap - 1;
			end else if (stim_q.size() != 0 && !(stim_q[0].drain && outcome_q.size() != 0)) begin
				item <= stim_q[0].beat;
				stim_q.pop_front();
				item_valid <= 1'b1;
				send_gap <= (cycle_count[10:9] == 2'b11) ? 0 : gap_len();
			end else begin
				item_valid <= 1'b0;
			end
		end
	end

	// result receiver stalls
	always @(negedge clk) begin
		if (stall_left != 0) begin
			result_stall <= 1'b1;
			stall_left <= stall_left - 1;
		end else begin
			result_stall <= 1'b0;
			stall_left <= (cycle_count[9:8] == 2'b00) ? 0 : gap_len();
		end
	end

	initial begin
		wait (idle_cycles >= WATCHDOG_LIMIT);
		$display("rv64i_integer_execute test failed");
		$finish;
	end

	initial begin
		int          count;
		int          fill;
		int          pick;
		logic [31:0] w;
		logic [2:0]  f3;
		for (int i = 0; i < NREGS; i++) xreg[i] = '0;
		ld_dest = '0;
		ld_size = '0;
		ld_uns = 1'b0;

		// directed: extremes, sign and zero extension, x0, branches, unsupported encodings
		queue_exec(enc_i(12'hfff, 5'd0, F3_ADD, 5'd1, OP_IMM));
		queue_exec({20'h80000, 5'd2, OP_LUI});
		queue_exec(enc_i(12'h000, 5'd0, {1'b0, SIZE_D}, 5'd5, OP_LOAD));
		queue_return(64'h8000_0000_0000_0001);
		queue_exec(enc_i(12'h7ff, 5'd1, {1'b0, SIZE_B}, 5'd3, OP_LOAD));
		queue_return(64'h0123_4567_89ab_cd80);
		queue_exec(enc_i(12'h800, 5'd2, {1'b1, SIZE_W}, 5'd8, OP_LOAD));
		queue_return(64'hffff_ffff_ffff_ffff);
		// load to x0: request goes out, return writes nothing
		queue_exec(enc_i(12'h010, 5'd1, {1'b0, SIZE_H}, 5'd0, OP_LOAD));
		queue_return(64'h0000_0000_0000_ffff);
		queue_return(64'hdead_beef_dead_beef);
		queue_exec(enc_i(12'hfff, 5'd2, F3_ADD, 5'd11, OP_IMM32));
		queue_exec(enc_r(F7_ALT, 5'd2, 5'd0, F3_ADD, 5'd12, OP_REG32));
		queue_exec(enc_i({TOP6_ARITH, 6'h3f}, 5'd5, F3_SR, 5'd14, OP_IMM));
		queue_exec(enc_i({TOP6_LOGIC, 6'h3f}, 5'd1, F3_SLL, 5'd13, OP_IMM));
		queue_exec(enc_i(12'h123, 5'd1, F3_ADD, 5'd0, OP_IMM));
		queue_exec(enc_i(12'h000, 5'd1, F3_ADD, 5'd16, OP_JALR));
		queue_beat(KIND_EXEC, {1'b1, 19'd0, 5'd17, OP_JAL}, 64'hffff_ffff_ffff_fffc, rand64());
		queue_beat(KIND_EXEC, {20'h80000, 5'd18, OP_AUIPC}, 64'hffff_ffff_ffff_ffff, rand64());
		queue_exec(enc_b(13'h1ff0, 5'd0, 5'd2, F3_BLT));
		queue_exec(enc_b(13'h0008, 5'd1, 5'd0, F3_BGEU));
		queue_exec({7'h7f, 5'd1, 5'd5, {1'b0, SIZE_D}, 5'h1f, OP_STORE});
		queue_exec({25'd0, OP_SYSTEM});
		queue_exec(enc_r(F7_MULDIV, 5'd2, 5'd1, F3_ADD, 5'd21, OP_REG));
		queue_exec(enc_i(12'h001, 5'd1, F3_SLL, 5'd22, OP_IMM32));
		queue_exec(enc_i({TOP6_ARITH, 6'h01}, 5'd1, F3_SLL, 5'd23, OP_IMM));

		// random: mostly load/return pairs and plain instructions, some stray returns
		count = 0;
		drain_next = 1'b1;
		while (count < RANDOM_ITEMS) begin
			if ($urandom_range(0, 199) == 0) drain_next = 1'b1;
			pick = $urandom_range(0, 99);
			if (pick < 30) begin
				w = random_insn();
				w[6:0] = OP_LOAD;
				f3 = 3'($urandom_range(0, 6));
				w[14:12] = ($urandom_range(0, 2) == 0) ? {1'b0, SIZE_D} : f3;
				queue_exec(w);
				count++;
				fill = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 3);
				repeat (fill) begin
					queue_exec(random_insn());
					count++;
				end
				queue_return(rand64());
				count++;
			end else if (pick < 34) begin
				queue_return(rand64());
				count++;
			end else begin
				queue_exec(random_insn());
				count++;
			end
		end

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (stim_q.size() != 0 || item_valid) @(posedge clk);
		while (outcome_q.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (wrong_count == 0 && outcome_q.size() == 0)
			$display("rv64i_integer_execute test passed");
		else
			$display("rv64i_integer_execute test failed");
		$finish;
	end

endmodule
